### sv/pnf_pkg.sv
// Shared constants and types of the fractal Perlin noise core.
package pnf_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int TBL_AW      = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 16;
    localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);
    localparam int ASUM_W      = 16 + OCT_W;
    localparam int DIVR_W      = ASUM_W + 1;
    localparam int TOT_W       = 48;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_DIMENSIONS   = 2'd0;
    localparam logic [1:0] CFG_OCTAVE_COUNT = 2'd1;
    localparam logic [1:0] CFG_PERSISTENCE  = 2'd2;
    localparam logic [1:0] CFG_LACUNARITY   = 2'd3;

    typedef logic signed [32:0] mul_op_t;
    typedef logic signed [63:0] mul_prod_t;
    typedef logic [TBL_AW-1:0]  tbl_addr_t;

endpackage

### sv/perlin_noise_fractal_core.sv
// Fractal Perlin noise core: sequencer around a shared multiplier, table and divider.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | operation, table_index, table_value, coord_x/y/z
//  m_      | out       | m_valid / m_ready    | noise_value
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A load item writes one table entry and leaves s_ready high. An evaluate item runs, per
// octave, the scaling and fade steps, the table reads and the lerps (one to three axes),
// then the final division; the shared multiplier and the single table read port serialise
// these steps. Reset needs no clearing pass. While an item is being evaluated s_ready is
// low; a finished result waits in the output register.
module perlin_noise_fractal_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [7:0]         s_table_index,
    input  logic [7:0]         s_table_value,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_noise_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import pnf_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SPL_I = 5'd1;
    localparam logic [4:0] ST_SPL_C = 5'd2;
    localparam logic [4:0] ST_FD_A  = 5'd3;
    localparam logic [4:0] ST_FD_B  = 5'd4;
    localparam logic [4:0] ST_FD_C  = 5'd5;
    localparam logic [4:0] ST_FD_D  = 5'd6;
    localparam logic [4:0] ST_H1_I  = 5'd7;
    localparam logic [4:0] ST_H1_C  = 5'd8;
    localparam logic [4:0] ST_H2_I  = 5'd9;
    localparam logic [4:0] ST_H2_C  = 5'd10;
    localparam logic [4:0] ST_H3_I  = 5'd11;
    localparam logic [4:0] ST_H3_C  = 5'd12;
    localparam logic [4:0] ST_GRAD  = 5'd13;
    localparam logic [4:0] ST_MIX_I = 5'd14;
    localparam logic [4:0] ST_MIX_C = 5'd15;
    localparam logic [4:0] ST_ACC_I = 5'd16;
    localparam logic [4:0] ST_ACC_C = 5'd17;
    localparam logic [4:0] ST_AMP_C = 5'd18;
    localparam logic [4:0] ST_FRQ_C = 5'd19;
    localparam logic [4:0] ST_DIV   = 5'd20;
    localparam logic [4:0] ST_OUT   = 5'd21;

    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

    logic [4:0]         state_reg;
    logic [1:0]         dims_reg;
    logic [4:0]         octave_count_reg;
    logic [15:0]        persistence_reg;
    logic [15:0]        lacunarity_reg;

    logic [1:0]         ax_reg;
    logic [2:0]         k_reg;
    logic [1:0]         lvl_reg;
    logic [OCT_W-1:0]   oct_reg;
    logic [OCT_W-1:0]   n_oct_reg;

    logic signed [31:0] c_reg [3];
    logic [TBL_AW-1:0]  cell_reg [3];
    logic [15:0]        t_reg [3];
    logic [16:0]        fade_reg [3];
    logic [15:0]        t2_reg;
    logic [7:0]         h1_reg [2];
    logic [7:0]         h2_reg [4];
    logic [7:0]         h3_reg [8];
    logic signed [19:0] g_reg [8];

    logic [31:0]        freq_reg;
    logic [15:0]        amp_reg;
    logic [ASUM_W-1:0]  asum_reg;
    logic signed [TOT_W-1:0] total_reg;
    logic signed [15:0] out_reg;
    logic               out_valid_reg;

    mul_op_t            mul_a, mul_b;
    mul_prod_t          prod_reg;
    tbl_addr_t          rd_addr;
    logic [7:0]         rd_data;
    logic               s_acc;
    logic [1:0]         dims_e;
    logic [20:0]        inner;
    logic signed [20:0] diff;
    logic signed [20:0] lat_r;
    logic [1:0]         lvl_sh;
    logic [1:0]         k_last;
    logic [OCT_W-1:0]   n_oct;
    logic               div_start, div_busy, div_done;
    logic [TOT_W-1:0]   div_quo, tot_mag;
    logic signed [19:0] g_calc [8];
    logic [63:0]        frac_field;
    logic [15:0]        t_new;
    logic signed [15:0] sat_q;

    assign s_ready       = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_valid       = out_valid_reg;
    assign m_noise_value = out_reg;
    assign s_acc         = s_valid && s_ready;
    assign dims_e        = (dims_reg == 2'd0) ? 2'd1 : dims_reg;

    always_comb begin
        if (octave_count_reg == 5'd0) begin
            n_oct = OCT_W'(1);
        end else if (32'(octave_count_reg) > MAX_OCTAVES) begin
            n_oct = OCT_W'(MAX_OCTAVES);
        end else begin
            n_oct = OCT_W'(octave_count_reg);
        end
    end

    // Lattice fraction of the scaled coordinate, brought to 16 fraction bits.
    assign frac_field = (64'(prod_reg) >> FRAC_BITS) & ((64'd1 << FRAC_BITS) - 64'd1);
    assign t_new = (FRAC_BITS >= 16) ? 16'(frac_field >> (FRAC_BITS - 16))
                                     : 16'(frac_field << (16 - FRAC_BITS));

    assign inner  = (21'(t2_reg) * 21'd6) + 21'd655360 - (21'(t_reg[ax_reg]) * 21'd15);
    assign diff   = 21'(g_reg[{k_reg[1:0], 1'b1}]) - 21'(g_reg[{k_reg[1:0], 1'b0}]);
    assign lat_r  = (dims_e == 2'd1) ? {g_reg[0], 1'b0} : 21'(g_reg[0]);
    assign lvl_sh = dims_e - 2'd1 - lvl_reg;
    assign k_last = 2'((3'd1 << lvl_sh) - 3'd1);

    function automatic logic signed [19:0] slope(input logic [1:0] dims, input logic [7:0] h,
                                                 input logic signed [17:0] x,
                                                 input logic signed [17:0] y,
                                                 input logic signed [17:0] z);
        logic [3:0]         hk;
        logic signed [19:0] a, b;
        hk = h[3:0];
        if (dims == 2'd1) begin
            slope = hk[0] ? -20'(x) : 20'(x);
        end else if (dims == 2'd2) begin
            slope = (hk[0] ? -20'(x) : 20'(x)) + (hk[1] ? -20'(y) : 20'(y));
        end else begin
            a = (hk < 4'd8) ? 20'(x) : 20'(y);
            if (hk < 4'd4) begin
                b = 20'(y);
            end else if (hk == 4'd12 || hk == 4'd14) begin
                b = 20'(x);
            end else begin
                b = 20'(z);
            end
            slope = (hk[0] ? -a : a) + (hk[1] ? -b : b);
        end
    endfunction

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            g_calc[j] = slope(dims_e,
                (dims_e == 2'd1) ? h1_reg[j % 2] : (dims_e == 2'd2) ? h2_reg[j % 4] : h3_reg[j],
                ((j & 1) != 0) ? 18'(t_reg[0]) - ONE_Q16 : 18'(t_reg[0]),
                ((j & 2) != 0) ? 18'(t_reg[1]) - ONE_Q16 : 18'(t_reg[1]),
                ((j & 4) != 0) ? 18'(t_reg[2]) - ONE_Q16 : 18'(t_reg[2]));
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SPL_I: begin
                mul_a = 33'(c_reg[ax_reg]);
                mul_b = {1'b0, freq_reg};
            end
            ST_FD_A: begin
                mul_a = {17'd0, t_reg[ax_reg]};
                mul_b = {17'd0, t_reg[ax_reg]};
            end
            ST_FD_B: begin
                mul_a = {17'd0, prod_reg[31:16]};
                mul_b = {17'd0, t_reg[ax_reg]};
            end
            ST_FD_C: begin
                mul_a = {17'd0, prod_reg[31:16]};
                mul_b = {12'd0, inner};
            end
            ST_MIX_I: begin
                mul_a = {16'd0, fade_reg[lvl_reg]};
                mul_b = 33'(diff);
            end
            ST_ACC_I: begin
                mul_a = 33'(lat_r);
                mul_b = {17'd0, amp_reg};
            end
            ST_ACC_C: begin
                mul_a = {17'd0, amp_reg};
                mul_b = {17'd0, persistence_reg};
            end
            ST_AMP_C: begin
                mul_a = {1'b0, freq_reg};
                mul_b = {17'd0, lacunarity_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_H1_I: rd_addr = cell_reg[0] + TBL_AW'(k_reg[0]);
            ST_H2_I: rd_addr = TBL_AW'(h1_reg[k_reg[0]]) + cell_reg[1] + TBL_AW'(k_reg[1]);
            ST_H3_I: rd_addr = TBL_AW'(h2_reg[k_reg[1:0]]) + cell_reg[2] + TBL_AW'(k_reg[2]);
            default: rd_addr = '0;
        endcase
    end

    assign div_start = (state_reg == ST_FRQ_C) && (oct_reg == n_oct_reg - 1'b1);
    assign tot_mag   = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);

    always_comb begin
        if (total_reg[TOT_W-1]) begin
            sat_q = (div_quo > TOT_W'(32768)) ? -16'sd32768 : 16'(-div_quo);
        end else begin
            sat_q = (div_quo > TOT_W'(32767)) ? 16'sd32767 : 16'(div_quo);
        end
    end

    pnf_table u_table (
        .aclk    (aclk),
        .wr_en   (s_acc && s_operation == OP_LOAD),
        .wr_addr (TBL_AW'(s_table_index)),
        .wr_data (s_table_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pnf_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    pnf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tot_mag),
        .divisor  ({asum_reg, 1'b0}),
        .busy_reg (div_busy),
        .done_reg (div_done),
        .quo_reg  (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg         <= 2'd3;
            octave_count_reg <= 5'd1;
            persistence_reg  <= 16'd16384;
            lacunarity_reg   <= 16'd8192;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIMENSIONS:   dims_reg         <= cfg_data[1:0];
                CFG_OCTAVE_COUNT: octave_count_reg <= cfg_data[4:0];
                CFG_PERSISTENCE:  persistence_reg  <= cfg_data;
                CFG_LACUNARITY:   lacunarity_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            oct_reg       <= '0;
            n_oct_reg     <= OCT_W'(1);
            ax_reg        <= '0;
            k_reg         <= '0;
            lvl_reg       <= '0;
        end else begin
            // In the output step a taken result is replaced by the new one below.
            if (out_valid_reg && m_ready && state_reg != ST_OUT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc && s_operation == OP_EVAL) begin
                        c_reg[0]  <= s_coord_x;
                        c_reg[1]  <= s_coord_y;
                        c_reg[2]  <= s_coord_z;
                        freq_reg  <= 32'd1 << FRAC_BITS;
                        amp_reg   <= 16'd32768;
                        asum_reg  <= '0;
                        total_reg <= '0;
                        oct_reg   <= '0;
                        n_oct_reg <= n_oct;
                        ax_reg    <= '0;
                        state_reg <= ST_SPL_I;
                    end
                end
                ST_SPL_I: state_reg <= ST_SPL_C;
                ST_SPL_C: begin
                    cell_reg[ax_reg] <= prod_reg[2*FRAC_BITS+TBL_AW-1:2*FRAC_BITS];
                    t_reg[ax_reg]    <= t_new;
                    if (ax_reg == 2'd2) begin
                        ax_reg    <= '0;
                        state_reg <= ST_FD_A;
                    end else begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= ST_SPL_I;
                    end
                end
                ST_FD_A: state_reg <= ST_FD_B;
                ST_FD_B: begin
                    t2_reg    <= prod_reg[31:16];
                    state_reg <= ST_FD_C;
                end
                ST_FD_C: state_reg <= ST_FD_D;
                ST_FD_D: begin
                    fade_reg[ax_reg] <= prod_reg[32:16];
                    if (ax_reg == 2'd2) begin
                        k_reg     <= '0;
                        state_reg <= ST_H1_I;
                    end else begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= ST_FD_A;
                    end
                end
                ST_H1_I: state_reg <= ST_H1_C;
                ST_H1_C: begin
                    h1_reg[k_reg[0]] <= rd_data;
                    if (k_reg == 3'd1) begin
                        k_reg     <= '0;
                        state_reg <= (dims_e == 2'd1) ? ST_GRAD : ST_H2_I;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_H1_I;
                    end
                end
                ST_H2_I: state_reg <= ST_H2_C;
                ST_H2_C: begin
                    h2_reg[k_reg[1:0]] <= rd_data;
                    if (k_reg == 3'd3) begin
                        k_reg     <= '0;
                        state_reg <= (dims_e == 2'd2) ? ST_GRAD : ST_H3_I;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_H2_I;
                    end
                end
                ST_H3_I: state_reg <= ST_H3_C;
                ST_H3_C: begin
                    h3_reg[k_reg] <= rd_data;
                    if (k_reg == 3'd7) begin
                        k_reg     <= '0;
                        state_reg <= ST_GRAD;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_H3_I;
                    end
                end
                ST_GRAD: begin
                    for (int j = 0; j < 8; j++) begin
                        g_reg[j] <= g_calc[j];
                    end
                    k_reg     <= '0;
                    lvl_reg   <= '0;
                    state_reg <= ST_MIX_I;
                end
                ST_MIX_I: state_reg <= ST_MIX_C;
                ST_MIX_C: begin
                    // Pairs collapse in place: entry k takes the lerp of entries 2k and 2k+1.
                    g_reg[k_reg[1:0]] <= g_reg[{k_reg[1:0], 1'b0}] + 20'(prod_reg >>> 16);
                    if (k_reg[1:0] == k_last) begin
                        k_reg <= '0;
                        if (lvl_reg == dims_e - 2'd1) begin
                            state_reg <= ST_ACC_I;
                        end else begin
                            lvl_reg   <= lvl_reg + 1'b1;
                            state_reg <= ST_MIX_I;
                        end
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_MIX_I;
                    end
                end
                ST_ACC_I: state_reg <= ST_ACC_C;
                ST_ACC_C: begin
                    total_reg <= total_reg + TOT_W'(prod_reg);
                    asum_reg  <= asum_reg + ASUM_W'(amp_reg);
                    state_reg <= ST_AMP_C;
                end
                ST_AMP_C: begin
                    amp_reg   <= (|prod_reg[63:31]) ? 16'hFFFF : prod_reg[30:15];
                    state_reg <= ST_FRQ_C;
                end
                ST_FRQ_C: begin
                    freq_reg <= (|prod_reg[63:44]) ? 32'hFFFF_FFFF : prod_reg[43:12];
                    if (div_start) begin
                        state_reg <= ST_DIV;
                    end else begin
                        oct_reg   <= oct_reg + 1'b1;
                        ax_reg    <= '0;
                        state_reg <= ST_SPL_I;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg       <= sat_q;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the divide step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        oct_reg < n_oct_reg)
        else $error("octave counter ran past the octave count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_EVAL |=> state_reg == ST_SPL_I)
        else $error("evaluate item did not start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> asum_reg != '0)
        else $error("zero amplitude sum at division");

endmodule

### sv/pnf_table.sv
// Permutation table memory with one write port and one registered read port.
module pnf_table (
    input  logic               aclk,
    input  logic               wr_en,
    input  pnf_pkg::tbl_addr_t wr_addr,
    input  logic [7:0]         wr_data,
    input  pnf_pkg::tbl_addr_t rd_addr,
    output logic [7:0]         rd_data
);
    import pnf_pkg::*;

    logic [7:0] mem [TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/pnf_mul.sv
// Shared signed multiplier with a registered product.
module pnf_mul (
    input  logic                aclk,
    input  pnf_pkg::mul_op_t    op_a,
    input  pnf_pkg::mul_op_t    op_b,
    output pnf_pkg::mul_prod_t  prod_reg
);
    import pnf_pkg::*;

    logic signed [65:0] full;

    assign full = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= full[63:0];
    end

endmodule

### sv/pnf_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
module pnf_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pnf_pkg::TOT_W-1:0]        dividend,
    input  logic [pnf_pkg::DIVR_W-1:0]       divisor,
    output logic                             busy_reg,
    output logic                             done_reg,
    output logic [pnf_pkg::TOT_W-1:0]        quo_reg
);
    import pnf_pkg::*;

    localparam int CNT_W = $clog2(TOT_W);

    logic [DIVR_W-1:0] den_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVR_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[TOT_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? DIVR_W'(trial - {1'b0, den_reg}) : DIVR_W'(trial);
                quo_reg <= {quo_reg[TOT_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |=> $stable(den_reg))
        else $error("divisor changed during division");

    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == '0)
        else $error("divider did not start");

endmodule

### tb/testbench.sv
// Self-checking testbench for the fractal Perlin noise core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pnf_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = OP_LOAD;
    logic [7:0]         s_table_index = '0;
    logic [7:0]         s_table_value = '0;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_y = '0;
    logic signed [31:0] s_coord_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_noise_value;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CFG_DIMENSIONS;
    logic [15:0]        cfg_data = '0;

    perlin_noise_fractal_core dut (.*);

    always #4 aclk = ~aclk;

    // Predictor state: its own copy of the table and the registers.
    logic [7:0]  perm_tbl [TABLE_SIZE];
    logic [1:0]  dims_reg = 2'd3;
    logic [4:0]  octaves_reg = 5'd1;
    logic [15:0] persist_reg = 16'd16384;
    logic [15:0] lacun_reg = 16'd8192;

    shortint  pending_samples [$];
    int       fail_count = 0;
    int       loads_sent = 0;
    int       evals_sent = 0;
    int       samples_checked = 0;
    bit       quiet_phase = 1'b0;
    longint   cycle_count = 0;

    function automatic longint perm(longint i);
        return longint'(perm_tbl[i & (TABLE_SIZE - 1)]);
    endfunction

    function automatic longint fade_q16(longint t);
        longint t2, t3;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        return (t3 * (6 * t2 + 10 * 65536 - 15 * t)) >>> 16;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint f);
        return a + ((f * (b - a)) >>> 16);
    endfunction

    function automatic longint grad2(longint h, longint x, longint y);
        return (h[0] ? -x : x) + (h[1] ? -y : y);
    endfunction

    function automatic longint grad3(longint h, longint x, longint y, longint z);
        longint k, a, b;
        k = h & 15;
        a = (k < 8) ? x : y;
        b = (k < 4) ? y : ((k == 12 || k == 14) ? x : z);
        return (k[0] ? -a : a) + (k[1] ? -b : b);
    endfunction

    function automatic longint octave_value(int nd, longint cx, longint cy, longint cz,
                                           longint x, longint y, longint z);
        longint x1, y1, z1, u, v, w, a, b, aa, ba, ab, bb, p0, p1;
        x1 = x - 65536;
        y1 = y - 65536;
        z1 = z - 65536;
        u = fade_q16(x);
        v = fade_q16(y);
        w = fade_q16(z);
        if (nd == 1) begin
            return 2 * lerp_q16(perm(cx) & 1 ? -x : x, perm(cx + 1) & 1 ? -x1 : x1, u);
        end
        a = perm(cx) + cy;
        b = perm(cx + 1) + cy;
        if (nd == 2) begin
            return lerp_q16(lerp_q16(grad2(perm(a), x, y), grad2(perm(b), x1, y), u),
                            lerp_q16(grad2(perm(a + 1), x, y1),
                                     grad2(perm(b + 1), x1, y1), u), v);
        end
        aa = perm(a) + cz;
        ba = perm(b) + cz;
        ab = perm(a + 1) + cz;
        bb = perm(b + 1) + cz;
        p0 = lerp_q16(lerp_q16(grad3(perm(aa), x, y, z), grad3(perm(ba), x1, y, z), u),
                      lerp_q16(grad3(perm(ab), x, y1, z), grad3(perm(bb), x1, y1, z), u), v);
        p1 = lerp_q16(lerp_q16(grad3(perm(aa + 1), x, y, z1),
                               grad3(perm(ba + 1), x1, y, z1), u),
                      lerp_q16(grad3(perm(ab + 1), x, y1, z1),
                               grad3(perm(bb + 1), x1, y1, z1), u), v);
        return lerp_q16(p0, p1, w);
    endfunction

    function automatic shortint noise_sample(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z);
        longint freq, amp, asum, total, q, px, py, pz;
        int nd, n;
        freq = 64'd1 << FRAC_BITS;
        amp = 32768;
        asum = 0;
        total = 0;
        nd = (dims_reg == 0) ? 1 : int'(dims_reg);
        n = (octaves_reg == 0) ? 1 : int'(octaves_reg);
        if (n > MAX_OCTAVES) n = MAX_OCTAVES;
        for (int i = 0; i < n; i++) begin
            px = longint'(x) * freq;
            py = longint'(y) * freq;
            pz = longint'(z) * freq;
            total += octave_value(nd, px >>> 32, py >>> 32, pz >>> 32,
                                  (px >>> 16) & 16'hFFFF, (py >>> 16) & 16'hFFFF,
                                  (pz >>> 16) & 16'hFFFF) * amp;
            asum += amp;
            amp = (amp * longint'(persist_reg)) >>> 15;
            if (amp > 65535) amp = 65535;
            freq = (freq * longint'(lacun_reg)) >>> 12;
            if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
        end
        q = total / (asum * 2);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return shortint'(q);
    endfunction

    // Sends one item; the expected sample is queued when the item is accepted.
    task automatic send_item(logic op, logic [7:0] idx, logic [7:0] val,
                             logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, bit typed, shortint want);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_table_index <= idx;
        s_table_value <= val;
        s_coord_x <= x;
        s_coord_y <= y;
        s_coord_z <= z;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        if (op == OP_LOAD) begin
            perm_tbl[idx] = val;
            loads_sent++;
        end else begin
            pending_samples.push_back(typed ? want : noise_sample(x, y, z));
            evals_sent++;
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_DIMENSIONS:   dims_reg = data[1:0];
            CFG_OCTAVE_COUNT: octaves_reg = data[4:0];
            CFG_PERSISTENCE:  persist_reg = data;
            CFG_LACUNARITY:   lacun_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(int nd, int oct, int pers, int lac);
        // The last item is already taken, so the input goes quiet before the writes.
        s_valid <= 1'b0;
        wait_idle();
        // Upper bits are junk on purpose; only the low bits of each field count.
        write_reg(CFG_DIMENSIONS, 16'(($urandom & 16'hFFFC) | nd[1:0]));
        write_reg(CFG_OCTAVE_COUNT, 16'(($urandom & 16'hFFE0) | oct[4:0]));
        write_reg(CFG_PERSISTENCE, pers[15:0]);
        write_reg(CFG_LACUNARITY, lac[15:0]);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    // Result side: random stalls and an in-order comparison.
    initial begin
        int stall;
        shortint want;
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_valid) break;
            end
            if (pending_samples.size() == 0) begin
                $display("%0t: sample %0d arrived with none expected", $time, m_noise_value);
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                samples_checked++;
                if (m_noise_value !== want) begin
                    $display("%0t: noise_value expected %0d, got %0d",
                             $time, want, m_noise_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("perlin_noise_fractal_core verification failed");
            $finish;
        end
    end

    typedef struct {
        logic               op;
        logic [7:0]         idx;
        logic [7:0]         val;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 typed;
        shortint            want;
    } stim_row_t;

    // Reset settings apply here. Points on whole lattice coordinates give zero.
    stim_row_t directed_rows [] = '{
        '{OP_EVAL, 8'h00, 8'h00, 32'sh0, 32'sh0, 32'sh0, 1'b1, 16'sd0},
        '{OP_EVAL, 8'hFF, 8'hFF, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
          1'b1, 16'sd0},
        '{OP_EVAL, 8'h00, 8'h00, -32'sh0005_0000, 32'sh00FF_0000, -32'sh0100_0000,
          1'b1, 16'sd0},
        '{OP_EVAL, 8'h00, 8'h00, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 0},
        '{OP_EVAL, 8'h00, 8'h00, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 0},
        '{OP_EVAL, 8'h00, 8'h00, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 1'b0, 0},
        '{OP_EVAL, 8'h00, 8'h00, 32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF, 1'b0, 0},
        '{OP_EVAL, 8'h00, 8'h00, 32'sh0000_0001, -32'sh0000_0001, 32'sh0000_8000, 1'b0, 0},
        '{OP_LOAD, 8'hFF, 8'hFF, 32'sh0, 32'sh0, 32'sh0, 1'b0, 0},
        '{OP_LOAD, 8'h00, 8'h00, 32'sh0, 32'sh0, 32'sh0, 1'b0, 0},
        '{OP_LOAD, 8'h55, 8'hAA, 32'sh0, 32'sh0, 32'sh0, 1'b0, 0},
        '{OP_LOAD, 8'hAA, 8'h55, 32'sh0, 32'sh0, 32'sh0, 1'b0, 0},
        '{OP_EVAL, 8'hA5, 8'h5A, -32'sh0000_8000, 32'sh0055_4000, -32'sh00AA_C000,
          1'b0, 0},
        '{OP_EVAL, 8'h00, 8'h00, 32'sh7FFF_0000, -32'sh7FFF_0000, 32'sh0000_FFFF, 1'b0, 0},
        '{OP_EVAL, 8'h00, 8'h00, -32'sh0000_0001, -32'sh0000_0001, -32'sh0000_0001,
          1'b0, 0}
    };

    // Phase settings: dimensions, octaves, persistence, lacunarity, item count.
    int phase_plan [][5] = '{
        '{1, 1, 0, 0, 80},
        '{2, 4, 65535, 65535, 80},
        '{3, 16, 16384, 8192, 20},
        '{0, 0, 32768, 4096, 80},
        '{3, 31, 0, 65535, 60},
        '{2, 2, 0, 0, 80},
        '{1, 16, 65535, 12288, 40},
        '{3, 2, 24576, 8192, 70}
    };

    initial begin
        stim_row_t r;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Every table entry is written before the first evaluation.
        for (int i = 0; i < TABLE_SIZE; i++)
            send_item(OP_LOAD, i[7:0], 8'($urandom), 0, 0, 0, 1'b0, '0);
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            send_item(r.op, r.idx, r.val, r.x, r.y, r.z, r.typed, r.want);
        end
        for (int p = 0; p < phase_plan.size() + 2; p++) begin
            if (p < phase_plan.size())
                configure(phase_plan[p][0], phase_plan[p][1], phase_plan[p][2],
                          phase_plan[p][3]);
            else
                configure($urandom_range(0, 3), $urandom_range(1, 5), $urandom & 16'hFFFF,
                          $urandom & 16'hFFFF);
            quiet_phase = (p % 3 == 2);
            repeat (p < phase_plan.size() ? phase_plan[p][4] : 50) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom,
                              $urandom, 1'b0, '0);
                else
                    send_item(OP_EVAL, 8'($urandom), 8'($urandom), rand_coord(),
                              rand_coord(), rand_coord(), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
        $display("Sent %0d table loads and %0d evaluations over %0d settings;",
                 loads_sent, evals_sent, phase_plan.size() + 3);
        $display("%0d noise samples compared, %0d mismatches.", samples_checked, fail_count);
        if (fail_count == 0)
            $display("perlin_noise_fractal_core verification clean");
        else
            $display("perlin_noise_fractal_core verification failed");
        $finish;
    end

endmodule
